// ===== rtl/nearest_partner_match_table_assert.svh =====
// assertion macros
`ifndef NEAREST_PARTNER_MATCH_TABLE_ASSERT_SVH
`define NEAREST_PARTNER_MATCH_TABLE_ASSERT_SVH
`define NPM_ASSERT_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define NPM_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/npm_pkg.sv =====
`default_nettype none
package npm_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_REMOVED   = 3'd1;
    localparam logic [2:0] ST_WRONG     = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_RAD, S_SCAN_OTHER, S_SCAN_OWN, S_FIX, S_NEAR, S_NEAR_ACC,
        S_WRITE, S_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/npm_dist.sv =====
`default_nettype none
// registered squared distance: differences, then squares, then a combinational sum
module npm_dist
(
    input  wire logic               clk,
    input  wire logic signed [15:0] ax,
    input  wire logic signed [15:0] ay,
    input  wire logic signed [15:0] bx,
    input  wire logic signed [15:0] by,
    output logic [34:0]             dist_sq
);
    logic signed [16:0] dx_reg, dy_reg;
    logic [33:0] sx_reg, sy_reg;

    always_ff @(posedge clk)
    begin
        dx_reg <= 17'(ax) - 17'(bx);
        dy_reg <= 17'(ay) - 17'(by);
        sx_reg <= 34'(dx_reg * dx_reg);
        sy_reg <= 34'(dy_reg * dy_reg);
    end

    assign dist_sq = 35'(sx_reg) + 35'(sy_reg);
endmodule
`default_nettype wire

// ===== rtl/nearest_partner_match_table.sv =====
`default_nettype none
// Two client tables (vehicles, riders) of TABLE_DEPTH slots in synchronous RAMs.
// A register word scans its own table for the id and a free slot, then the
// opposite table for the id, checks the radius, and scans the opposite table
// again for the nearest partner, one slot per cycle through the RAM read port.
// Remove words scan only their own table, and rejected register words skip the
// nearest-partner scan. One word in flight; the result is held until taken.
module nearest_partner_match_table
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic [15:0]        client_id,
    input  wire logic               client_kind,
    input  wire logic signed [15:0] x_coord,
    input  wire logic signed [15:0] y_coord,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic                    pair_found,
    output logic [15:0]             partner_id,
    output logic signed [15:0]      partner_x,
    output logic signed [15:0]      partner_y,
    output logic [34:0]             partner_dist_sq,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data
);
    import npm_pkg::*;

    // RAM word: id, pos(x,y), pair(id,x,y)
    logic [95:0] mem0 [TABLE_DEPTH];
    logic [95:0] mem1 [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] val0_reg, val1_reg;

    state_t state_reg, state_next;
    logic [15:0] rad_reg;
    logic mode_reg, kind_reg;
    logic [15:0] id_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] ridx_reg;
    logic rvld_reg;
    logic [95:0] rd0_reg, rd1_reg;
    logic hit_reg, free_reg;
    logic [IDX_W-1:0] hidx_reg, fidx_reg;
    logic best_reg;
    logic [IDX_W-1:0] bidx_reg;
    logic [34:0] bd_reg;
    logic [15:0] bid_reg;
    logic [31:0] bpos_reg;
    logic [95:0] own_word_reg;
    logic [1:0] wstep_reg;
    logic [2:0] st_reg;
    logic ov_reg;
    logic [1:0] dpipe_reg;
    logic [IDX_W-1:0] di1_reg, di2_reg;
    logic [47:0] dpair1_reg, dpair2_reg;

    logic [95:0] rd_other, rd_own;
    logic vo_bit, vw_bit;
    logic [34:0] dsq;
    logic [33:0] r2, p2;
    logic signed [15:0] ox, oy;

    assign rd_other = kind_reg ? rd0_reg : rd1_reg;
    assign rd_own = kind_reg ? rd1_reg : rd0_reg;
    assign vo_bit = kind_reg ? val0_reg[ridx_reg] : val1_reg[ridx_reg];
    assign vw_bit = kind_reg ? val1_reg[ridx_reg] : val0_reg[ridx_reg];
    assign ox = state_reg == S_RAD ? 16'sd0 : rd_other[79:64];
    assign oy = state_reg == S_RAD ? 16'sd0 : rd_other[63:48];

    npm_dist u_dist
    (
        .clk(clk), .ax(ox), .ay(oy), .bx(x_reg), .by(y_reg), .dist_sq(dsq)
    );

    assign r2 = 34'(32'(rad_reg) * 32'(rad_reg));
    assign p2 = dsq[33:0];

    assign in_stall = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign status = st_reg;
    assign pair_found = ov_reg && st_reg == ST_ACCEPTED && best_reg;
    assign partner_id = pair_found ? bid_reg : 16'd0;
    assign partner_x = pair_found ? bpos_reg[31:16] : 16'sd0;
    assign partner_y = pair_found ? bpos_reg[15:0] : 16'sd0;
    assign partner_dist_sq = pair_found ? bd_reg : 35'd0;

    // read issued at cnt_reg; data and its index show up in the cycle after
    logic scan_issue;
    assign scan_issue = (state_reg == S_SCAN_OWN || state_reg == S_SCAN_OTHER ||
                         state_reg == S_NEAR) && cnt_reg != CNT_W'(TABLE_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_SCAN_OWN;
            S_SCAN_OWN: if (rvld_reg && ridx_reg == IDX_W'(TABLE_DEPTH - 1))
                state_next = mode_reg ? S_FIX : S_SCAN_OTHER;
            S_SCAN_OTHER: if (rvld_reg && ridx_reg == IDX_W'(TABLE_DEPTH - 1))
                state_next = S_RAD;
            S_RAD: if (cnt_reg == CNT_W'(3)) state_next = S_FIX;
            S_FIX: state_next = (mode_reg || st_reg != ST_ACCEPTED || (!hit_reg && !free_reg))
                ? S_OUT : S_NEAR;
            S_NEAR: if (dpipe_reg == 2'd0 && !rvld_reg && cnt_reg == CNT_W'(TABLE_DEPTH))
                state_next = S_WRITE;
            S_WRITE: if (wstep_reg == 2'd1) state_next = S_OUT;
            S_OUT: if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rad_reg <= 16'd32767;
            val0_reg <= '0;
            val1_reg <= '0;
            ov_reg <= 1'b0;
            rvld_reg <= 1'b0;
            dpipe_reg <= 2'd0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid) rad_reg <= cfg_data;
            ov_reg <= state_next == S_OUT;
            dpipe_reg <= {dpipe_reg[0], state_reg == S_NEAR && rvld_reg};
            rvld_reg <= scan_issue;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        cnt_reg <= '0;
                    end
                S_SCAN_OWN, S_SCAN_OTHER, S_NEAR:
                begin
                    if (state_next != state_reg) cnt_reg <= '0;
                    else if (scan_issue) cnt_reg <= cnt_reg + 1'b1;
                end
                S_RAD: cnt_reg <= cnt_reg + 1'b1;
                S_FIX: cnt_reg <= '0;
                S_WRITE:
                    if (wstep_reg == 2'd0)
                    begin
                        if (kind_reg) val1_reg[fidx_reg] <= 1'b1;
                        else val0_reg[fidx_reg] <= 1'b1;
                    end
                default: ;
            endcase
            if (state_reg == S_FIX && mode_reg && hit_reg)
            begin
                if (kind_reg) val1_reg[hidx_reg] <= 1'b0;
                else val0_reg[hidx_reg] <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rd0_reg <= mem0[cnt_reg[IDX_W-1:0]];
        rd1_reg <= mem1[cnt_reg[IDX_W-1:0]];
        ridx_reg <= cnt_reg[IDX_W-1:0];
        di1_reg <= ridx_reg;
        di2_reg <= di1_reg;
        dpair1_reg <= {rd_other[95:80], rd_other[79:48]};
        dpair2_reg <= dpair1_reg;
        case (state_reg)
            S_IDLE:
            begin
                mode_reg <= mode;
                kind_reg <= client_kind;
                id_reg <= client_id;
                x_reg <= x_coord;
                y_reg <= y_coord;
                hit_reg <= 1'b0;
                free_reg <= 1'b0;
                best_reg <= 1'b0;
                st_reg <= ST_ACCEPTED;
                wstep_reg <= 2'd0;
            end
            S_SCAN_OWN:
                if (rvld_reg)
                begin
                    if (vw_bit && rd_own[95:80] == id_reg && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                        hidx_reg <= ridx_reg;
                        own_word_reg <= rd_own;
                    end
                    if (!vw_bit && !free_reg)
                    begin
                        free_reg <= 1'b1;
                        fidx_reg <= ridx_reg;
                    end
                end
            S_SCAN_OTHER:
                if (rvld_reg)
                begin
                    if (vo_bit && rd_other[95:80] == id_reg) st_reg <= ST_WRONG;
                end
            S_RAD:
                if (cnt_reg == CNT_W'(2) && p2 > r2) st_reg <= ST_OUTSIDE;
            S_FIX:
            begin
                if (mode_reg) st_reg <= hit_reg ? ST_REMOVED : ST_NOT_FOUND;
                else if (st_reg == ST_ACCEPTED)
                begin
                    if (hit_reg) fidx_reg <= hidx_reg;
                    else if (!free_reg) st_reg <= ST_FULL;
                    if (!hit_reg) own_word_reg <= '0;
                end
            end
            S_NEAR:
            begin
                if (dpipe_reg[1] && (kind_reg ? val0_reg[di2_reg] : val1_reg[di2_reg])
                    && (!best_reg || dsq < bd_reg))
                begin
                    best_reg <= 1'b1;
                    bidx_reg <= di2_reg;
                    bd_reg <= dsq;
                    bid_reg <= dpair2_reg[47:32];
                    bpos_reg <= dpair2_reg[31:0];
                end
            end
            S_WRITE: wstep_reg <= wstep_reg + 1'b1;
            default: ;
        endcase
    end

    // RAM writes
    logic [95:0] own_new;
    assign own_new = {id_reg, x_reg, y_reg,
                      best_reg ? {bid_reg, bpos_reg} : own_word_reg[47:0]};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE && wstep_reg == 2'd0)
        begin
            if (kind_reg) mem1[fidx_reg] <= own_new;
            else mem0[fidx_reg] <= own_new;
        end
        if (state_reg == S_WRITE && wstep_reg == 2'd1 && best_reg)
        begin
            if (kind_reg) mem0[bidx_reg] <= {bid_reg, bpos_reg, id_reg, x_reg, y_reg};
            else mem1[bidx_reg] <= {bid_reg, bpos_reg, id_reg, x_reg, y_reg};
        end
    end

    `include "nearest_partner_match_table_assert.svh"
    `NPM_ASSERT_IMPL(a_busy_stall, state_reg != S_IDLE, in_stall)
    `NPM_ASSERT_IMPL(a_pair_ok, pair_found, status == ST_ACCEPTED)
    `NPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))
endmodule
`default_nettype wire

// ===== test/tb_nearest_partner_match_table.sv =====
`timescale 1ns / 1ps

module tb_nearest_partner_match_table;
    import npm_pkg::*;

    typedef struct {
        logic               mode;
        logic [15:0]        id;
        logic               kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } client_req_t;

    typedef struct {
        logic [2:0]         status;
        logic               found;
        logic [15:0]        pid;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [34:0]        dsq;
    } match_res_t;

    class match_scoreboard;
        bit                 used [2][TABLE_DEPTH];
        logic [15:0]        ids  [2][TABLE_DEPTH];
        logic signed [15:0] xs   [2][TABLE_DEPTH];
        logic signed [15:0] ys   [2][TABLE_DEPTH];
        logic [15:0]        radius;
        match_res_t         awaited [$];
        int                 errors;

        function new();
            radius = 16'd32767;
            errors = 0;
            foreach (used[t, i]) used[t][i] = 0;
        endfunction

        function int lookup(int t, logic [15:0] id);
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (used[t][i] && ids[t][i] == id) return i;
            return -1;
        endfunction

        function void note(client_req_t r);
            match_res_t e;
            int own, oth, slot, best;
            longint dx, dy, d, best_d;
            own = r.kind;
            oth = 1 - own;
            e = '{default: '0};
            if (r.mode) begin
                slot = lookup(own, r.id);
                if (slot < 0) e.status = ST_NOT_FOUND;
                else begin
                    used[own][slot] = 0;
                    e.status = ST_REMOVED;
                end
            end else if (longint'(r.x) * r.x + longint'(r.y) * r.y >
                         longint'(radius) * longint'(radius)) begin
                e.status = ST_OUTSIDE;
            end else if (lookup(oth, r.id) >= 0) begin
                e.status = ST_WRONG;
            end else begin
                slot = lookup(own, r.id);
                if (slot < 0)
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (!used[own][i]) begin
                            slot = i;
                            break;
                        end
                if (slot < 0) e.status = ST_FULL;
                else begin
                    used[own][slot] = 1;
                    ids[own][slot] = r.id;
                    xs[own][slot] = r.x;
                    ys[own][slot] = r.y;
                    e.status = ST_ACCEPTED;
                    best = -1;
                    best_d = 0;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (used[oth][i]) begin
                            dx = longint'(xs[oth][i]) - longint'(r.x);
                            dy = longint'(ys[oth][i]) - longint'(r.y);
                            d = dx * dx + dy * dy;
                            if (best < 0 || d < best_d) begin
                                best = i;
                                best_d = d;
                            end
                        end
                    if (best >= 0) begin
                        e.found = 1;
                        e.pid = ids[oth][best];
                        e.px = xs[oth][best];
                        e.py = ys[oth][best];
                        e.dsq = best_d[34:0];
                    end
                end
            end
            awaited.push_back(e);
        endfunction

        function void field(string name, longint exp, longint act);
            if (exp != act) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            end
        endfunction

        function void check(match_res_t a);
            match_res_t e;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d", $time, a.status);
                return;
            end
            e = awaited.pop_front();
            field("status", e.status, a.status);
            field("pair_found", e.found, a.found);
            field("partner_id", e.pid, a.pid);
            field("partner_x", e.px, a.px);
            field("partner_y", e.py, a.py);
            field("partner_dist_sq", e.dsq, a.dsq);
        endfunction
    endclass

    localparam longint LIMIT = 1000000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic               mode = 0;
    logic [15:0]        client_id = 0;
    logic               client_kind = 0;
    logic signed [15:0] x_coord = 0;
    logic signed [15:0] y_coord = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [2:0]         status;
    logic               pair_found;
    logic [15:0]        partner_id;
    logic signed [15:0] partner_x;
    logic signed [15:0] partner_y;
    logic [34:0]        partner_dist_sq;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = 0;

    match_scoreboard sb = new();
    longint cycles = 0;
    int hold_req = 0;
    bit calm = 0;

    nearest_partner_match_table DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .client_id(client_id), .client_kind(client_kind),
        .x_coord(x_coord), .y_coord(y_coord),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .pair_found(pair_found), .partner_id(partner_id),
        .partner_x(partner_x), .partner_y(partner_y),
        .partner_dist_sq(partner_dist_sq),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("[nearest_partner_match_table] ERROR");
            $finish;
        end
    end

    function int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // receiver
    initial
    begin
        int hold_cnt, stall_left;
        match_res_t a;
        hold_cnt = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                a.status = status;
                a.found = pair_found;
                a.pid = partner_id;
                a.px = partner_x;
                a.py = partner_y;
                a.dsq = partner_dist_sq;
                sb.check(a);
            end
            if (hold_req > 0)
            begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1;
            end
            else
            begin
                out_stall <= 0;
                stall_left = idle_len();
            end
        end
    end

    task automatic send(client_req_t r);
        int g;
        mode <= r.mode;
        client_id <= r.id;
        client_kind <= r.kind;
        x_coord <= r.x;
        y_coord <= r.y;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        sb.note(r);
        g = idle_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic word(bit m, int id, bit k, int x, int y);
        client_req_t r;
        r.mode = m;
        r.id = 16'(id);
        r.kind = k;
        r.x = 16'(x);
        r.y = 16'(y);
        send(r);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic set_radius(logic [15:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.radius = v;
    endtask

    function automatic logic signed [15:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 16'sh8000;
        if (r < 10) return 16'sh7fff;
        if (r < 15) return 16'sd0;
        if (r < 55) return 16'($urandom_range(0, 2000) - 1000);
        return 16'($urandom);
    endfunction

    function automatic client_req_t rand_req();
        client_req_t r;
        int p;
        p = $urandom_range(0, 99);
        r.mode = ($urandom_range(0, 99) < 20);
        r.id = (p < 75) ? 16'($urandom_range(1, 40)) : (p < 82) ? 16'd0 : 16'($urandom);
        r.kind = 1'($urandom);
        r.x = rand_coord();
        r.y = rand_coord();
        return r;
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed
        word(0, 1, 0, 0, 0);
        word(0, 2, 1, 32767, 32767);
        word(0, 2, 1, -32768, 0);
        word(0, 2, 1, 100, -200);
        word(0, 2, 0, 3, 3);
        word(0, 1, 0, 5, 5);
        word(0, 4, 0, -5, -5);
        word(0, 3, 1, 0, 0);
        word(0, 0, 1, 7, -7);
        word(0, 65535, 0, -100, -100);
        word(1, 1, 0, 0, 0);
        word(1, 1, 0, 0, 0);
        word(1, 65535, 1, 0, 0);
        word(0, 5, 1, 32767, 0);
        set_radius(16'd0);
        word(0, 7, 0, 0, 0);
        word(0, 8, 0, 1, 0);
        word(0, 9, 1, 0, -1);
        set_radius(16'd46341);
        word(0, 10, 0, -32768, -32768);
        word(0, 11, 1, 32767, 32767);
        word(1, 10, 0, 0, 0);
        word(1, 11, 1, 0, 0);

        // receiver holds off while the sender keeps going
        hold_req = 400;
        for (int i = 0; i < 6; i++) send(rand_req());
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                1: set_radius(16'd32767);
                2: set_radius(16'd1000);
                3: set_radius(16'($urandom_range(0, 46341)));
                4: set_radius(16'd46341);
                default: ;
            endcase
            calm = (ph == 5);
            if (ph == 4)
            begin
                // fill the vehicle table past its depth
                for (int i = 0; i < TABLE_DEPTH + 3; i++)
                    word(0, 200 + i, 0, rand_coord(), rand_coord());
                for (int i = 0; i < 8; i++)
                    word(0, 300 + i, 1, rand_coord(), rand_coord());
                for (int i = 0; i < TABLE_DEPTH + 3; i++)
                    word(1, 200 + i, 0, 0, 0);
            end
            for (int i = 0; i < 95; i++) send(rand_req());
            if (ph == 2) drain();
        end
        calm = 0;

        in_valid <= 0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("[nearest_partner_match_table] OK");
        else
            $display("[nearest_partner_match_table] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/npm_pkg.sv
rtl/npm_dist.sv
rtl/nearest_partner_match_table.sv
test/tb_nearest_partner_match_table.sv
